@@ rtl/core/sprite_rle_decoder_assert.svh @@
// Assertion macros shared by the sprite RLE decoder checkers.
// Depends on nothing; every macro samples on the rising edge of clock, off while reset.
`ifndef SPRITE_RLE_DECODER_ASSERT_SVH
`define SPRITE_RLE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define SRD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/srd_pkg.sv @@
// Shared types and constants of the sprite RLE decoder.
// Depends on nothing; used by the top level, the front and back stages and the checker.
`default_nettype none

package srd_pkg;

   localparam int CFG_BITS       = 10;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CODE_BITS      = 8;
   localparam int LEN_BITS       = 18;
   localparam int OUT_LEN_BITS   = 17;
   localparam int POS_BITS       = 19;
   localparam int SIZE_BITS      = 20;
   localparam int OUT_ADDR_BITS  = 24;

   localparam int DEFAULT_MAX_DIMENSION = 512;
   localparam int DEFAULT_ADDRESS_BITS  = 24;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 10'd32;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 10'd40;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CODE_BITS-1:0] CODE_RUN = 8'hFE;
   localparam logic [CODE_BITS-1:0] CODE_END = 8'hFF;

   localparam logic [POS_BITS-1:0] POSITION_MAX = '1;

   typedef enum logic [1:0] {
      CMD_NOP = 2'd0,
      CMD_RUN = 2'd1,
      CMD_END = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      restart;
      logic [LEN_BITS-1:0]       len;
      logic [CODE_BITS-1:0]      value;
   } cmd_type;

   typedef struct packed {
      logic [OUT_ADDR_BITS-1:0]  pixel_address;
      logic [OUT_LEN_BITS-1:0]   run_length;
      logic [CODE_BITS-1:0]      pixel_value;
      logic                      frame_end;
      logic                      overflow;
   } rsp_type;

   // Zero acts as one, anything above the limit acts as the limit.
   function automatic logic [CFG_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v,
                                                     input int max_dim);
      logic [CFG_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_BITS'(1);
      end else if (int'(v) > max_dim) begin
         r = CFG_BITS'(max_dim);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/sprite_rle_decoder.sv @@
// Sprite RLE decoder: takes one compressed code byte per cycle while req_full is low and
// writes one result per decoded run (start address, length, palette index, frame end,
// overflow). Commands and results are registered in their queues before a result shows
// on the rsp_ ports. A command queue of four entries parts the byte classifier from the
// run stage, and a two-entry result queue parts the run stage from the consumer, so
// either side may stall without losing throughput. Bytes that give no result (run
// markers, zero counts) are not queued unless they carry a restart. Write csr_ registers
// only while the decoder is idle; changes reach the run stage through the registered
// frame size. Depends on srd_pkg, srd_fifo, srd_front and srd_back.
`default_nettype none

module sprite_rle_decoder #(
   parameter int MAX_DIMENSION = srd_pkg::DEFAULT_MAX_DIMENSION,
   parameter int ADDRESS_BITS  = srd_pkg::DEFAULT_ADDRESS_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [srd_pkg::CODE_BITS-1:0]       req_code_byte,
   input  wire logic                                req_restart,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic      [srd_pkg::OUT_ADDR_BITS-1:0]   rsp_pixel_address,
   output logic      [srd_pkg::OUT_LEN_BITS-1:0]    rsp_run_length,
   output logic      [srd_pkg::CODE_BITS-1:0]       rsp_pixel_value,
   output logic                                     rsp_frame_end,
   output logic                                     rsp_overflow,
   input  wire logic                                csr_we,
   input  wire logic [srd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [srd_pkg::CFG_BITS-1:0]        csr_wdata
);

   import srd_pkg::*;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   logic [CFG_BITS-1:0]  width_ff, height_ff;
   logic [SIZE_BITS-1:0] frame_size_ff;

   cmd_type cmd_wr, cmd_head;
   rsp_type rsp_wr, rsp_head;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic    out_push, out_full;

   // Registers hold clamped dimensions.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_dim(WIDTH_RESET, MAX_DIMENSION);
         height_ff <= clamp_dim(HEIGHT_RESET, MAX_DIMENSION);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= clamp_dim(csr_wdata, MAX_DIMENSION);
            CSR_FRAME_HEIGHT: height_ff <= clamp_dim(csr_wdata, MAX_DIMENSION);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      frame_size_ff <= SIZE_BITS'(width_ff) * SIZE_BITS'(height_ff);
   end

   srd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_code_byte (req_code_byte),
      .req_restart   (req_restart),
      .frame_width   (width_ff),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd           (cmd_wr)
   );

   assign req_full = cmd_full;

   srd_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_head),
      .empty   (cmd_empty)
   );

   srd_back #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_head),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .frame_size (frame_size_ff),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (rsp_wr)
   );

   srd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (rsp_wr),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_head),
      .empty   (rsp_empty)
   );

   assign rsp_pixel_address = rsp_head.pixel_address;
   assign rsp_run_length    = rsp_head.run_length;
   assign rsp_pixel_value   = rsp_head.pixel_value;
   assign rsp_frame_end     = rsp_head.frame_end;
   assign rsp_overflow      = rsp_head.overflow;

endmodule

`default_nettype wire

@@ rtl/core/srd_fifo.sv @@
// Small register queue with a combinational head, used between the decoder stages.
// Depends on nothing; width and depth come from parameters.
`default_nettype none

module srd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/srd_front.sv @@
// Front stage: accepts code bytes, tracks the stream phase and turns bytes into commands.
// Depends on srd_pkg.
`default_nettype none

module srd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   input  wire logic [srd_pkg::CODE_BITS-1:0] req_code_byte,
   input  wire logic                         req_restart,
   input  wire logic [srd_pkg::CFG_BITS-1:0]  frame_width,
   input  wire logic                         cmd_full,
   output logic                              cmd_push,
   output srd_pkg::cmd_type                  cmd
);

   import srd_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_BODY   = 3'b010,
      PH_COUNT  = 3'b100
   } phase_type;

   phase_type phase_ff, phase_in, phase_cur;
   logic      accept;

   assign accept    = req_push && !cmd_full;
   assign phase_cur = req_restart ? PH_HEADER : phase_ff;

   always_comb begin
      cmd.kind    = CMD_NOP;
      cmd.restart = req_restart;
      cmd.len     = '0;
      cmd.value   = '0;
      phase_in    = phase_ff;
      case (phase_cur)
         PH_BODY: begin
            case (req_code_byte)
               CODE_RUN: begin
                  phase_in = PH_COUNT;
               end
               CODE_END: begin
                  cmd.kind = CMD_END;
                  phase_in = PH_HEADER;
               end
               default: begin
                  cmd.kind  = CMD_RUN;
                  cmd.len   = LEN_BITS'(1);
                  cmd.value = req_code_byte;
               end
            endcase
         end
         PH_COUNT: begin
            cmd.kind = (req_code_byte != '0) ? CMD_RUN : CMD_NOP;
            cmd.len  = LEN_BITS'(req_code_byte);
            phase_in = PH_BODY;
         end
         default: begin
            // header byte counts blank rows
            cmd.kind = (req_code_byte != '0) ? CMD_RUN : CMD_NOP;
            cmd.len  = LEN_BITS'(req_code_byte) * LEN_BITS'(frame_width);
            phase_in = PH_BODY;
         end
      endcase
   end

   // Drop plain no-ops; a restart must still reach the back to clear its position.
   assign cmd_push = accept && ((cmd.kind != CMD_NOP) || req_restart);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/srd_back.sv @@
// Back stage: holds frame base and position, turns commands into framebuffer writes.
// Depends on srd_pkg.
`default_nettype none

module srd_back #(
   parameter int ADDRESS_BITS = srd_pkg::DEFAULT_ADDRESS_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire srd_pkg::cmd_type              cmd,
   input  wire logic                          cmd_empty,
   output logic                               cmd_pop,
   input  wire logic [srd_pkg::SIZE_BITS-1:0] frame_size,
   input  wire logic                          out_full,
   output logic                               out_push,
   output srd_pkg::rsp_type                   out_data
);

   import srd_pkg::*;

   logic [ADDRESS_BITS-1:0] base_ff, base_in, base_cur;
   logic [POS_BITS-1:0]     pos_ff, pos_in, pos_cur;
   logic [ADDRESS_BITS-1:0] address;
   logic [SIZE_BITS-1:0]    end_pos;
   logic                    fire;

   assign base_cur = cmd.restart ? '0 : base_ff;
   assign pos_cur  = cmd.restart ? '0 : pos_ff;
   assign address  = base_cur + ADDRESS_BITS'(pos_cur);
   assign end_pos  = SIZE_BITS'(pos_cur) + SIZE_BITS'(cmd.len);

   // A no-op needs no room in the result queue.
   assign fire     = !cmd_empty && ((cmd.kind == CMD_NOP) || !out_full);
   assign cmd_pop  = fire;
   assign out_push = fire && (cmd.kind != CMD_NOP);

   always_comb begin
      out_data.pixel_address = OUT_ADDR_BITS'(address);
      out_data.run_length    = OUT_LEN_BITS'(cmd.len);
      out_data.pixel_value   = cmd.value;
      out_data.frame_end     = 1'b0;
      out_data.overflow      = (end_pos > frame_size);
      base_in                = base_cur;
      pos_in                 = pos_cur;
      case (cmd.kind)
         CMD_RUN: begin
            pos_in = (end_pos > SIZE_BITS'(POSITION_MAX)) ? POSITION_MAX
                                                          : POS_BITS'(end_pos);
         end
         CMD_END: begin
            out_data.run_length  = '0;
            out_data.pixel_value = '0;
            out_data.frame_end   = 1'b1;
            out_data.overflow    = 1'b0;
            base_in              = base_cur + ADDRESS_BITS'(frame_size);
            pos_in               = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         pos_ff  <= '0;
      end else if (fire) begin
         base_ff <= base_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/srd_checker.sv @@
// Port-level checker for the sprite RLE decoder, attached to the top level by bind.
// Depends on srd_pkg and sprite_rle_decoder_assert.svh.
`default_nettype none

`include "sprite_rle_decoder_assert.svh"

module srd_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_full,
   input  wire logic                                rsp_empty,
   input  wire logic                                rsp_pop,
   input  wire logic [srd_pkg::OUT_ADDR_BITS-1:0]   rsp_pixel_address,
   input  wire logic [srd_pkg::OUT_LEN_BITS-1:0]    rsp_run_length,
   input  wire logic [srd_pkg::CODE_BITS-1:0]       rsp_pixel_value,
   input  wire logic                                rsp_frame_end,
   input  wire logic                                rsp_overflow
);

   // A frame end carries no pixels and never overflows.
   `SRD_ASSERT_NOW(a_end_is_empty, !rsp_empty && rsp_frame_end, (rsp_run_length == '0) && (rsp_pixel_value == '0) && !rsp_overflow, "frame end with pixels or overflow")

   // Every other result writes at least one pixel.
   `SRD_ASSERT_NOW(a_run_nonzero, !rsp_empty && !rsp_frame_end, rsp_run_length != '0, "zero-length run")

   // Both queues come out of reset empty.
   `SRD_ASSERT_NOW(a_reset_clears, $past(reset), rsp_empty && !req_full, "queues not clear after reset")

   // An untaken result holds.
   `SRD_ASSERT_NEXT(a_rsp_holds, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_pixel_address) && $stable(rsp_run_length) && $stable(rsp_pixel_value) && $stable(rsp_frame_end), "stalled result changed")

endmodule

bind sprite_rle_decoder srd_checker u_checker (.*);

`default_nettype wire
